// ===== hw/rtl/trs_pkg.sv =====
// trs_pkg: constants and types shared by the model matrix builder
// no dependencies
package trs_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_FRAC  = 30;
   localparam int CORDIC_W     = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

   function automatic logic signed [CORDIC_W-1:0] step_angle(input int unsigned i);
      logic signed [CORDIC_W-1:0] r;
      r = '0;
      unique case (i)
         0: r = 34'sd536870912;
         1: r = 34'sd316933406;
         2: r = 34'sd167458907;
         3: r = 34'sd85004756;
         4: r = 34'sd42667331;
         5: r = 34'sd21354465;
         6: r = 34'sd10680862;
         7: r = 34'sd5340245;
         8: r = 34'sd2670163;
         9: r = 34'sd1335087;
         10: r = 34'sd667544;
         11: r = 34'sd333772;
         12: r = 34'sd166886;
         13: r = 34'sd83443;
         14: r = 34'sd41722;
         15: r = 34'sd20861;
         16: r = 34'sd10430;
         17: r = 34'sd5215;
         18: r = 34'sd2608;
         19: r = 34'sd1304;
         20: r = 34'sd652;
         21: r = 34'sd326;
         22: r = 34'sd163;
         23: r = 34'sd81;
         default: r = '0;
      endcase
      return r;
   endfunction

   // input item payload, pos_x in the lowest bits
   typedef struct packed {
      logic signed [31:0] scale_z;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_x;
      logic signed [31:0] pos_z;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
   } vec_type;

endpackage

// ===== hw/rtl/trs_model_matrix_builder.sv =====
// trs_model_matrix_builder: builds the column-major trs model matrix, four columns per item out
// depends on trs_pkg
//
//  channel | dir | fields
//  req_    | in  | tdata: pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, angle_x/y/z
//  rsp_    | out | tdata: column_index, elem_row0..3 ; tlast: last_column
//
// each item walks a 24-stage cordic pipeline (one rotation step per stage, three
// angles side by side), then four product stages and a column buffer; results
// leave one column per cycle while rsp_tready is high, and the whole pipeline
// waits while the buffer holds a matrix until its last column is taken. column 0
// is offered first and column 3 last. synchronous reset clears valid bits and the
// column counter only. a stall at the output freezes the whole pipeline, nothing is lost.
module trs_model_matrix_builder
   import trs_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int ANGLE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, scale_x, scale_y, scale_z (32 each), angle_x, angle_y,
   // angle_z (16 each)
   input  logic [239:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // column_index (2), elem_row0, elem_row1, elem_row2, elem_row3 (32 each), 6 pad
   output logic [135:0] rsp_tdata,
   output logic         rsp_tlast
);

   localparam int NS = CORDIC_STEPS;
   localparam int SH = CORDIC_FRAC - FRAC_BITS;
   localparam int PW = 64;
   // trig values and rotation entries stay within a few units
   localparam int TW = FRAC_BITS + 4;

   typedef logic signed [CORDIC_W-1:0] cw_type;
   typedef logic signed [PW-1:0] pw_type;
   typedef logic signed [TW-1:0] tw_type;
   typedef logic signed [2*TW-1:0] tp_type;
   typedef logic signed [TW+31:0] sp_type;

   function automatic tw_type fmul(input tw_type a, input tw_type b);
      tp_type p;
      p = a * b + (tp_type'(1) <<< (FRAC_BITS - 1));
      p = p >>> FRAC_BITS;
      return p[TW-1:0];
   endfunction

   function automatic pw_type fmul_s(input tw_type a, input logic signed [31:0] b);
      sp_type p;
      p = a * b + (sp_type'(1) <<< (FRAC_BITS - 1));
      p = p >>> FRAC_BITS;
      return pw_type'(p);
   endfunction

   function automatic logic signed [31:0] sat(input pw_type v);
      if (v > pw_type'(64'sd2147483647)) return 32'sh7fffffff;
      if (v < -pw_type'(64'sd2147483648)) return 32'sh80000000;
      return v[31:0];
   endfunction

   // pipeline advance: stall whole pipe while column buffer busy
   logic adv;
   logic [1:0] col_ff, col_in;
   logic out_v_ff, out_v_in;

   // cordic stages
   logic   cv_ff   [NS+1];
   vec_type cd_ff  [NS+1];
   cw_type cx_ff   [NS+1][3];
   cw_type cy_ff   [NS+1][3];
   cw_type cz_ff   [NS+1][3];
   logic   cf_ff   [NS+1][3];

   logic [15:0] ang [3];
   assign ang[0] = req_tdata[207:192];
   assign ang[1] = req_tdata[223:208];
   assign ang[2] = req_tdata[239:224];

   // trig results and products
   logic   p1v_ff, p2v_ff, p3v_ff, p4v_ff;
   vec_type p1d_ff, p2d_ff, p3d_ff, p4d_ff;
   tw_type s_ff[3], c_ff[3];
   tw_type czsy_ff, szsy_ff, czcy_ff, szcy_ff, cysx_ff, cycx_ff, szcx_ff, szsx_ff;
   tw_type czcx_ff, czsx_ff, nsy_ff, sxp_ff, cxp_ff;
   tw_type r_ff[3][3];
   logic signed [31:0] m_ff[3][3];

   logic busy;
   assign busy = out_v_ff && !(rsp_tready && col_ff == 2'd3);
   assign adv  = !busy;
   assign req_tready = adv;

   // valid bits travel with the payload
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NS; i++) cv_ff[i] <= 1'b0;
         p1v_ff <= 1'b0;
         p2v_ff <= 1'b0;
         p3v_ff <= 1'b0;
         p4v_ff <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= req_tvalid;
         for (int i = 0; i < NS; i++) cv_ff[i+1] <= cv_ff[i];
         p1v_ff <= cv_ff[NS];
         p2v_ff <= p1v_ff;
         p3v_ff <= p2v_ff;
         p4v_ff <= p3v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_ff[0] <= req_tdata[191:0];
         for (int a = 0; a < 3; a++) begin
            logic [31:0] ph;
            logic flip;
            // bits above ANGLE_BITS shift out as whole turns
            ph = 32'(ang[a]) << (32 - ANGLE_BITS);
            flip = ph[31] ^ ph[30];
            if (flip) ph = ph - 32'h80000000;
            cf_ff[0][a] <= flip;
            cx_ff[0][a] <= CORDIC_X0;
            cy_ff[0][a] <= '0;
            cz_ff[0][a] <= cw_type'(signed'(ph));
         end
         for (int i = 0; i < NS; i++) begin
            cd_ff[i+1] <= cd_ff[i];
            for (int a = 0; a < 3; a++) begin
               cf_ff[i+1][a] <= cf_ff[i][a];
               if (!cz_ff[i][a][CORDIC_W-1]) begin
                  cx_ff[i+1][a] <= cx_ff[i][a] - (cy_ff[i][a] >>> i);
                  cy_ff[i+1][a] <= cy_ff[i][a] + (cx_ff[i][a] >>> i);
                  cz_ff[i+1][a] <= cz_ff[i][a] - step_angle(i);
               end else begin
                  cx_ff[i+1][a] <= cx_ff[i][a] + (cy_ff[i][a] >>> i);
                  cy_ff[i+1][a] <= cy_ff[i][a] - (cx_ff[i][a] >>> i);
                  cz_ff[i+1][a] <= cz_ff[i][a] + step_angle(i);
               end
            end
         end
         // round trig to FRAC_BITS
         p1d_ff <= cd_ff[NS];
         for (int a = 0; a < 3; a++) begin
            cw_type xs, ys, xr, yr;
            xs = cx_ff[NS][a];
            ys = cy_ff[NS][a];
            if (cf_ff[NS][a]) begin xs = -xs; ys = -ys; end
            xr = (xs + (cw_type'(1) <<< (SH - 1))) >>> SH;
            yr = (ys + (cw_type'(1) <<< (SH - 1))) >>> SH;
            c_ff[a] <= xr[TW-1:0];
            s_ff[a] <= yr[TW-1:0];
         end
         // first products
         p2d_ff <= p1d_ff;
         czsy_ff <= fmul(c_ff[2], s_ff[1]);
         szsy_ff <= fmul(s_ff[2], s_ff[1]);
         czcy_ff <= fmul(c_ff[2], c_ff[1]);
         szcy_ff <= fmul(s_ff[2], c_ff[1]);
         cysx_ff <= fmul(c_ff[1], s_ff[0]);
         cycx_ff <= fmul(c_ff[1], c_ff[0]);
         szcx_ff <= fmul(s_ff[2], c_ff[0]);
         szsx_ff <= fmul(s_ff[2], s_ff[0]);
         czcx_ff <= fmul(c_ff[2], c_ff[0]);
         czsx_ff <= fmul(c_ff[2], s_ff[0]);
         nsy_ff  <= -s_ff[1];
         sxp_ff  <= s_ff[0];
         cxp_ff  <= c_ff[0];
         // rotation entries
         p3d_ff <= p2d_ff;
         r_ff[0][0] <= czcy_ff;
         r_ff[0][1] <= fmul(czsy_ff, sxp_ff) - szcx_ff;
         r_ff[0][2] <= fmul(czsy_ff, cxp_ff) + szsx_ff;
         r_ff[1][0] <= szcy_ff;
         r_ff[1][1] <= fmul(szsy_ff, sxp_ff) + czcx_ff;
         r_ff[1][2] <= fmul(szsy_ff, cxp_ff) - czsx_ff;
         r_ff[2][0] <= nsy_ff;
         r_ff[2][1] <= cysx_ff;
         r_ff[2][2] <= cycx_ff;
         // scale
         p4d_ff <= p3d_ff;
         for (int i = 0; i < 3; i++) begin
            m_ff[i][0] <= sat(fmul_s(r_ff[i][0], p3d_ff.scale_x));
            m_ff[i][1] <= sat(fmul_s(r_ff[i][1], p3d_ff.scale_y));
            m_ff[i][2] <= sat(fmul_s(r_ff[i][2], p3d_ff.scale_z));
         end
      end
   end

   // column buffer holding the finished matrix
   logic signed [31:0] b_ff[3][3], b_in[3][3];
   logic signed [31:0] t_ff[3], t_in[3];

   always_comb begin
      out_v_in = out_v_ff;
      col_in   = col_ff;
      b_in     = b_ff;
      t_in     = t_ff;
      if (out_v_ff && rsp_tready) begin
         if (col_ff == 2'd3) out_v_in = 1'b0;
         col_in = col_ff + 2'd1;
      end
      if (adv && p4v_ff) begin
         out_v_in = 1'b1;
         col_in   = 2'd0;
         b_in     = m_ff;
         t_in[0]  = p4d_ff.pos_x;
         t_in[1]  = p4d_ff.pos_y;
         t_in[2]  = p4d_ff.pos_z;
      end
   end

   always_ff @(posedge clock) begin
      b_ff <= b_in;
      t_ff <= t_in;
      if (reset) begin
         out_v_ff <= 1'b0;
         col_ff   <= '0;
      end else begin
         out_v_ff <= out_v_in;
         col_ff   <= col_in;
      end
   end

   logic signed [31:0] e0, e1, e2, e3;
   always_comb begin
      if (col_ff == 2'd3) begin
         e0 = t_ff[0];
         e1 = t_ff[1];
         e2 = t_ff[2];
         e3 = 32'sd1 <<< FRAC_BITS;
      end else begin
         e0 = b_ff[0][col_ff];
         e1 = b_ff[1][col_ff];
         e2 = b_ff[2][col_ff];
         e3 = '0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = (col_ff == 2'd3);
   assign rsp_tdata  = {6'd0, e3, e2, e1, e0, col_ff};

endmodule

// ===== verif/trs_model_matrix_builder_tb.sv =====
// trs_model_matrix_builder_tb: random and directed stream test of the model matrix builder,
// predicts each column with a local cordic and fixed-point model and checks field by field
// depends on trs_pkg and trs_model_matrix_builder
`timescale 1ns / 100ps

module trs_model_matrix_builder_tb
   import trs_pkg::*;
;

   localparam int FRAC   = 16;
   localparam int ABITS  = 16;
   localparam int STEPS  = 24;
   localparam int CFRAC  = 30;
   localparam longint X0 = 652032874;
   localparam int LIMIT  = 400000;

   typedef struct packed {
      logic [15:0] ang_z;
      logic [15:0] ang_y;
      logic [15:0] ang_x;
      logic [31:0] scl_z;
      logic [31:0] scl_y;
      logic [31:0] scl_x;
      logic [31:0] pz;
      logic [31:0] py;
      logic [31:0] px;
   } pose_t;

   typedef struct packed {
      logic        last;
      logic [31:0] e3;
      logic [31:0] e2;
      logic [31:0] e1;
      logic [31:0] e0;
      logic [1:0]  col;
   } column_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [239:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;
   logic         rsp_tlast;

   pose_t   pose_queue[$];
   column_t column_queue[$];
   int      errors;
   int      cycles;
   bit      hold_rsp;
   bit      no_idle;

   trs_model_matrix_builder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint fmul(longint a, longint b);
      return fshift(a * b + (64'sd1 <<< (FRAC - 1)), FRAC);
   endfunction

   function automatic longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void sin_cos(logic [15:0] ang, output longint sn, output longint cs);
      logic [31:0] ph;
      logic        flip;
      longint      z, x, y, dx, dy;
      ph = 32'(ang) << (32 - ABITS);
      flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
      if (flip) ph = ph - 32'h8000_0000;
      z = longint'(signed'(ph));
      x = X0;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(step_angle(i));
         end else begin
            x += dx; y -= dy; z += longint'(step_angle(i));
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      cs = fshift(x + (64'sd1 <<< (CFRAC - FRAC - 1)), CFRAC - FRAC);
      sn = fshift(y + (64'sd1 <<< (CFRAC - FRAC - 1)), CFRAC - FRAC);
   endfunction

   task automatic predict_columns(pose_t p);
      longint  sx, cx, sy, cy, sz, cz;
      longint  r[3][3];
      longint  s[3];
      column_t c;
      sin_cos(p.ang_x, sx, cx);
      sin_cos(p.ang_y, sy, cy);
      sin_cos(p.ang_z, sz, cz);
      r[0][0] = fmul(cz, cy);
      r[0][1] = fmul(fmul(cz, sy), sx) - fmul(sz, cx);
      r[0][2] = fmul(fmul(cz, sy), cx) + fmul(sz, sx);
      r[1][0] = fmul(sz, cy);
      r[1][1] = fmul(fmul(sz, sy), sx) + fmul(cz, cx);
      r[1][2] = fmul(fmul(sz, sy), cx) - fmul(cz, sx);
      r[2][0] = -sy;
      r[2][1] = fmul(cy, sx);
      r[2][2] = fmul(cy, cx);
      s[0] = longint'(signed'(p.scl_x));
      s[1] = longint'(signed'(p.scl_y));
      s[2] = longint'(signed'(p.scl_z));
      for (int j = 0; j < 3; j++) begin
         c.col  = 2'(j);
         c.e0   = 32'(sat(fmul(r[0][j], s[j])));
         c.e1   = 32'(sat(fmul(r[1][j], s[j])));
         c.e2   = 32'(sat(fmul(r[2][j], s[j])));
         c.e3   = '0;
         c.last = 1'b0;
         column_queue.push_back(c);
      end
      c.col = 2'd3; c.e0 = p.px; c.e1 = p.py; c.e2 = p.pz;
      c.e3 = 32'(1) << FRAC; c.last = 1'b1;
      column_queue.push_back(c);
   endtask

   // driver: pops a new pose only after the previous one was taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_columns(pose_t'(req_tdata));
         end
         if ((!req_tvalid || req_tready) ) begin
            if (pose_queue.size() > 0 && (no_idle || $urandom_range(99) >= 23)) begin
               req_tdata  <= pose_queue.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      column_t got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = column_t'({rsp_tlast, rsp_tdata[129:0]});
            if (column_queue.size() == 0) begin
               $display("%0t unexpected column: actual %h", $time, got);
               errors++;
            end else begin
               want = column_queue.pop_front();
               if (got.col !== want.col || got.e0 !== want.e0 || got.e1 !== want.e1 ||
                   got.e2 !== want.e2 || got.e3 !== want.e3 || got.last !== want.last) begin
                  $display("%0t column mismatch: expected %h actual %h", $time, want, got);
                  errors++;
               end
            end
         end
         rsp_tready <= !hold_rsp && (no_idle || $urandom_range(99) >= 23);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[trs_model_matrix_builder] ERROR");
         $finish;
      end
   end

   function automatic pose_t random_pose();
      pose_t p;
      p.px = $urandom; p.py = $urandom; p.pz = $urandom;
      // mostly modest scales, sometimes full range to hit saturation
      p.scl_x = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(262144)) - 32'd131072;
      p.scl_y = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(262144)) - 32'd131072;
      p.scl_z = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(262144)) - 32'd131072;
      p.ang_x = 16'($urandom); p.ang_y = 16'($urandom); p.ang_z = 16'($urandom);
      return p;
   endfunction

   task automatic wait_drained();
      while (pose_queue.size() > 0 || req_tvalid || column_queue.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      pose_t p;
      logic [15:0] angs[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                               16'h3FFF, 16'h7FFF, 16'hBFFF, 16'hFFFF};
      errors = 0; cycles = 0; hold_rsp = 0; no_idle = 0;
      req_tvalid = 0; req_tdata = '0; rsp_tready = 0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: quadrant edges, unit and extreme scales, saturation
      foreach (angs[k]) begin
         p = '0;
         p.px = 32'h7FFF_FFFF; p.py = 32'h8000_0000; p.pz = 32'hFFFF_FFFF;
         p.scl_x = 32'h0001_0000; p.scl_y = 32'hFFFF_0000; p.scl_z = 32'h0002_0000;
         p.ang_x = angs[k]; p.ang_y = angs[(k + 3) % 8]; p.ang_z = angs[(k + 5) % 8];
         pose_queue.push_back(p);
      end
      p = '0; p.scl_x = 32'h7FFF_FFFF; p.scl_y = 32'h8000_0000; p.scl_z = 32'h7FFF_FFFF;
      p.ang_z = 16'h2000;
      pose_queue.push_back(p);
      p.scl_x = 32'h8000_0000; p.scl_y = 32'h7FFF_FFFF; p.scl_z = 32'h8000_0000;
      p.ang_x = 16'h6000; p.ang_y = 16'hE000;
      pose_queue.push_back(p);
      p = '0; p.scl_x = 32'h0000_0001; p.scl_y = 32'hFFFF_FFFF; p.scl_z = 32'h0;
      p.ang_x = 16'h5555; p.ang_y = 16'hAAAA; p.ang_z = 16'h1234;
      pose_queue.push_back(p);
      wait_drained();

      // receiver holds off while the sender keeps offering
      hold_rsp = 1;
      for (int n = 0; n < 20; n++) pose_queue.push_back(random_pose());
      repeat (150) @(posedge clock);
      hold_rsp = 0;
      wait_drained();

      // stretch with no idling on either side
      no_idle = 1;
      for (int n = 0; n < 30; n++) pose_queue.push_back(random_pose());
      wait_drained();
      no_idle = 0;

      for (int n = 0; n < 60; n++) pose_queue.push_back(random_pose());
      wait_drained();
      repeat (60) @(posedge clock);
      if (errors == 0 && column_queue.size() == 0) begin
         $display("[trs_model_matrix_builder] OK");
      end else begin
         $display("[trs_model_matrix_builder] ERROR");
      end
      $finish;
   end

endmodule
